@@ rtl/core/c3vs_pkg.sv @@
// c3vs_pkg: shared widths, types and register codes of the 3x3 valid convolution block
// no dependencies; used by every module in rtl/core

package c3vs_pkg;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W    = 16;
    localparam int PROD_W   = 32;
    localparam int PART_W   = 34;
    localparam int SUM_W    = 35;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 5;
    localparam int IMG_W_W  = 6;
    localparam int IMG_H_W  = 11;
    localparam int KROW_W   = 48;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    localparam logic [IMG_W_W-1:0] RST_IMG_W = 6'd28;
    localparam logic [IMG_H_W-1:0] RST_IMG_H = 11'd28;

    typedef enum logic [2:0] {
        REG_IMG_W = 3'd0,
        REG_IMG_H = 3'd1,
        REG_K_TOP = 3'd2,
        REG_K_MID = 3'd3,
        REG_K_BOT = 3'd4
    } reg_idx_t;

    // position info of one item as it leaves the scan counters
    typedef struct packed {
        logic             prod;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } scan_t;

    // one window column, index 0 is the oldest row
    typedef logic [2:0][PIX_W-1:0] column_t;

endpackage

@@ rtl/core/c3vs_scan_ctrl.sv @@
// c3vs_scan_ctrl: raster column/row counters with size clamping and wrap
// depends on c3vs_pkg

module c3vs_scan_ctrl #(
    parameter int MAX_WIDTH  = c3vs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3vs_pkg::DEF_MAX_HEIGHT,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [c3vs_pkg::IMG_W_W-1:0]  image_width,
    input  logic [c3vs_pkg::IMG_H_W-1:0]  image_height,
    output logic [CW-1:0]                 col_addr,
    output c3vs_pkg::scan_t               scan
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [31:0]   w_val, h_val, last_col_full, last_row_full, row_m2, col_m2;
    logic [CW-1:0] last_col, col_eff;
    logic [RW-1:0] last_row;
    logic          col_end, row_end;

    always_comb begin
        w_val = 32'(image_width);
        if (w_val < 32'd3) begin
            w_val = 32'd3;
        end else if (w_val > 32'(MAX_WIDTH)) begin
            w_val = 32'(MAX_WIDTH);
        end
        h_val = 32'(image_height);
        if (h_val < 32'd3) begin
            h_val = 32'd3;
        end else if (h_val > 32'(MAX_HEIGHT)) begin
            h_val = 32'(MAX_HEIGHT);
        end
        last_col_full = w_val - 32'd1;
        last_row_full = h_val - 32'd1;
        last_col      = last_col_full[CW-1:0];
        last_row      = last_row_full[RW-1:0];

        // a width shrink can leave the column past the new row end
        col_eff = (col_reg > last_col) ? last_col : col_reg;
        col_end = (col_eff == last_col);
        row_end = (row_reg >= last_row);

        row_m2 = 32'(row_reg) - 32'd2;
        col_m2 = 32'(col_eff) - 32'd2;
        scan.prod = (32'(row_reg) >= 32'd2) && (32'(col_eff) >= 32'd2);
        scan.row  = row_m2[c3vs_pkg::ROW_W-1:0];
        scan.col  = col_m2[c3vs_pkg::COL_W-1:0];
        scan.last = col_end && row_end;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_eff + CW'(1);
            end
        end
    end

    assign col_addr = col_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && col_end && row_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at frame end");

endmodule

@@ rtl/core/c3vs_line_buf.sv @@
// c3vs_line_buf: two line memories holding the previous two input rows
// depends on c3vs_pkg; feeds the newest window column into the cell chain

module c3vs_line_buf #(
    parameter int MAX_WIDTH = c3vs_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        wr_en,
    input  logic [CW-1:0]               rd_addr,
    input  logic [c3vs_pkg::PIX_W-1:0]  pixel,
    output c3vs_pkg::column_t           col_out
);

    logic [c3vs_pkg::PIX_W-1:0] mem_prev  [MAX_WIDTH];
    logic [c3vs_pkg::PIX_W-1:0] mem_prev2 [MAX_WIDTH];
    logic [c3vs_pkg::PIX_W-1:0] rd_prev_reg, rd_prev2_reg, px_reg;
    logic [CW-1:0]              wr_addr_reg;

    // read at accept into registers, then written back from them at the same column once the pipeline advances
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_prev_reg  <= mem_prev[rd_addr];
            rd_prev2_reg <= mem_prev2[rd_addr];
            px_reg       <= pixel;
            wr_addr_reg  <= rd_addr;
        end
        if (wr_en) begin
            mem_prev2[wr_addr_reg] <= rd_prev_reg;
            mem_prev[wr_addr_reg]  <= px_reg;
        end
    end

    assign col_out[0] = rd_prev2_reg;
    assign col_out[1] = rd_prev_reg;
    assign col_out[2] = px_reg;

endmodule

@@ rtl/core/c3vs_col_cell.sv @@
// c3vs_col_cell: one window column, its three products and their partial sum
// depends on c3vs_pkg; chained so each cell hands its column to the older neighbor

module c3vs_col_cell (
    input  logic                                aclk,
    input  logic                                shift_en,
    input  logic                                en,
    input  c3vs_pkg::column_t                   col_in,
    input  c3vs_pkg::column_t                   coef,
    output c3vs_pkg::column_t                   col_out,
    output logic signed [c3vs_pkg::PART_W-1:0]  partial
);

    c3vs_pkg::column_t                   col_reg;
    logic signed [c3vs_pkg::PIX_W-1:0]   samp [3];
    logic signed [c3vs_pkg::PIX_W-1:0]   wgt  [3];
    logic signed [c3vs_pkg::PROD_W-1:0]  prod_next [3];
    logic signed [c3vs_pkg::PROD_W-1:0]  prod_reg  [3];
    logic signed [c3vs_pkg::PART_W-1:0]  part_next, part_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            samp[i]      = col_reg[i];
            wgt[i]       = coef[i];
            prod_next[i] = samp[i] * wgt[i];
        end
        part_next = c3vs_pkg::PART_W'(prod_reg[0]) + c3vs_pkg::PART_W'(prod_reg[1])
                  + c3vs_pkg::PART_W'(prod_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            part_reg <= part_next;
        end
    end

    assign col_out = col_reg;
    assign partial = part_reg;

endmodule

@@ rtl/core/conv3x3_valid_stream_top.sv @@
// conv3x3_valid_stream_top: 3x3 valid convolution over a raster pixel stream
// depends on c3vs_pkg, c3vs_scan_ctrl, c3vs_line_buf and c3vs_col_cell
//
// usage:
//   s_ channel carries one signed 16-bit pixel per item in raster order.
//   m_ channel carries one result per pixel at row >= 2 and column >= 2:
//   the exact 35-bit sum of the 3x3 window times the kernel, plus the
//   output row and column; m_tlast marks the last result of the frame.
//   the APB port holds width, height and three packed kernel rows; change
//   them only while the block is drained.
// timing:
//   one item per clock sustained while the output is not held; the three column
//   cells each run three parallel 16x16 multipliers, so nothing iterates. a
//   result is registered in turn at memory read, window shift, products,
//   partial sums and final sum before it shows on m_tvalid.
// reset: counters, pipeline valid bits and configuration registers go to their defaults;
//   line memories and window need no clearing.
// stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; no item is lost or repeated.

module conv3x3_valid_stream_top #(
    parameter int MAX_WIDTH  = c3vs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3vs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: pixel[15:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [c3vs_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: conv_value[34:0], out_row[44:35], out_col[49:45], zero[55:50]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [c3vs_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3vs_pkg::APB_AW-1:0]   paddr,
    input  logic [c3vs_pkg::APB_DW-1:0]   pwdata,
    output logic [c3vs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef struct packed {
        logic            valid;
        c3vs_pkg::scan_t info;
    } meta_t;

    logic [c3vs_pkg::IMG_W_W-1:0] img_w_reg;
    logic [c3vs_pkg::IMG_H_W-1:0] img_h_reg;
    logic [c3vs_pkg::KROW_W-1:0]  krow_reg [3];
    c3vs_pkg::reg_idx_t           reg_idx;
    logic                         cfg_wr;

    logic              en, accept;
    logic [CW-1:0]     col_addr;
    c3vs_pkg::scan_t   scan;
    meta_t             meta_reg [4];

    c3vs_pkg::column_t                  col_link [1:3];
    c3vs_pkg::column_t                  coef     [3];
    logic signed [c3vs_pkg::PART_W-1:0] partial  [3];
    logic signed [c3vs_pkg::SUM_W-1:0]  sum_next;

    logic                               m_valid_reg;
    logic signed [c3vs_pkg::SUM_W-1:0]  m_conv_reg;
    logic [c3vs_pkg::ROW_W-1:0]         m_row_reg;
    logic [c3vs_pkg::COL_W-1:0]         m_col_reg;
    logic                               m_last_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = c3vs_pkg::reg_idx_t'(paddr[c3vs_pkg::APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            c3vs_pkg::REG_IMG_W: prdata = c3vs_pkg::APB_DW'(img_w_reg);
            c3vs_pkg::REG_IMG_H: prdata = c3vs_pkg::APB_DW'(img_h_reg);
            c3vs_pkg::REG_K_TOP: prdata = c3vs_pkg::APB_DW'(krow_reg[0]);
            c3vs_pkg::REG_K_MID: prdata = c3vs_pkg::APB_DW'(krow_reg[1]);
            c3vs_pkg::REG_K_BOT: prdata = c3vs_pkg::APB_DW'(krow_reg[2]);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= c3vs_pkg::RST_IMG_W;
            img_h_reg <= c3vs_pkg::RST_IMG_H;
            for (int i = 0; i < 3; i++) begin
                krow_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                c3vs_pkg::REG_IMG_W: img_w_reg   <= pwdata[c3vs_pkg::IMG_W_W-1:0];
                c3vs_pkg::REG_IMG_H: img_h_reg   <= pwdata[c3vs_pkg::IMG_H_W-1:0];
                c3vs_pkg::REG_K_TOP: krow_reg[0] <= pwdata[c3vs_pkg::KROW_W-1:0];
                c3vs_pkg::REG_K_MID: krow_reg[1] <= pwdata[c3vs_pkg::KROW_W-1:0];
                c3vs_pkg::REG_K_BOT: krow_reg[2] <= pwdata[c3vs_pkg::KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output register is held
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    c3vs_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .image_width  (img_w_reg),
        .image_height (img_h_reg),
        .col_addr     (col_addr),
        .scan         (scan)
    );

    c3vs_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line (
        .aclk    (aclk),
        .en      (en),
        .wr_en   (en && meta_reg[0].valid),
        .rd_addr (col_addr),
        .pixel   (s_tdata[c3vs_pkg::PIX_W-1:0]),
        .col_out (col_link[3])
    );

    // cell k holds window column k; new columns enter at cell 2
    for (genvar k = 0; k < 3; k++) begin : g_cell
        for (genvar ki = 0; ki < 3; ki++) begin : g_coef
            assign coef[k][ki] = krow_reg[ki][c3vs_pkg::PIX_W*k +: c3vs_pkg::PIX_W];
        end
        if (k == 0) begin : g_tail
            c3vs_col_cell u_cell (
                .aclk     (aclk),
                .shift_en (en && meta_reg[0].valid),
                .en       (en),
                .col_in   (col_link[k+1]),
                .coef     (coef[k]),
                .col_out  (),
                .partial  (partial[k])
            );
        end else begin : g_mid
            c3vs_col_cell u_cell (
                .aclk     (aclk),
                .shift_en (en && meta_reg[0].valid),
                .en       (en),
                .col_in   (col_link[k+1]),
                .coef     (coef[k]),
                .col_out  (col_link[k]),
                .partial  (partial[k])
            );
        end
    end

    assign sum_next = c3vs_pkg::SUM_W'(partial[0]) + c3vs_pkg::SUM_W'(partial[1])
                    + c3vs_pkg::SUM_W'(partial[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                meta_reg[i].valid <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            meta_reg[0].valid <= accept;
            meta_reg[0].info  <= scan;
            for (int i = 1; i < 4; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
            m_valid_reg <= meta_reg[3].valid && meta_reg[3].info.prod;
            m_conv_reg  <= sum_next;
            m_row_reg   <= meta_reg[3].info.row;
            m_col_reg   <= meta_reg[3].info.col;
            m_last_reg  <= meta_reg[3].info.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_col_reg, m_row_reg, m_conv_reg};
    assign m_tlast  = m_last_reg;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(meta_reg[3]))
        else $error("pipeline moved while output stalled");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(meta_reg[3].valid && meta_reg[3].info.prod))
        else $error("result without a producing item");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !meta_reg[0].valid))
        else $error("valid bits not cleared by reset");

endmodule

@@ test/conv3x3_valid_stream_top_test.sv @@
// conv3x3_valid_stream_top_test: self-checking bench for the 3x3 valid convolution block
// depends on c3vs_pkg and conv3x3_valid_stream_top; reads no files, needs no arguments
// predicts results from a line-store and window model or directed values, checks m_ items

module conv3x3_valid_stream_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 8;
    localparam int LONG_HOLD   = 250;
    localparam int RAND_ITEMS  = 1200;
    localparam int NARROW_RUN  = 450;

    typedef struct packed {
        logic signed [c3vs_pkg::SUM_W-1:0] value;
        logic [c3vs_pkg::ROW_W-1:0]        row;
        logic [c3vs_pkg::COL_W-1:0]        col;
        logic                              last;
    } conv_res_t;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t                  kind;
        c3vs_pkg::reg_idx_t          regi;
        logic [c3vs_pkg::APB_DW-1:0] wval;
        logic [c3vs_pkg::PIX_W-1:0]  pix;
        bit                          typed;
        conv_res_t                   res;
    } dir_step_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [c3vs_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [c3vs_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [c3vs_pkg::APB_AW-1:0]   paddr    = '0;
    logic [c3vs_pkg::APB_DW-1:0]   pwdata   = '0;
    logic [c3vs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    conv3x3_valid_stream_top #(
        .MAX_WIDTH  (c3vs_pkg::DEF_MAX_WIDTH),
        .MAX_HEIGHT (c3vs_pkg::DEF_MAX_HEIGHT)
    ) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // local copy of the block: configuration, line stores, window, scan counters
    logic [c3vs_pkg::IMG_W_W-1:0] cfg_w = c3vs_pkg::RST_IMG_W;
    logic [c3vs_pkg::IMG_H_W-1:0] cfg_h = c3vs_pkg::RST_IMG_H;
    logic [c3vs_pkg::KROW_W-1:0]  kern [3] = '{default: '0};
    logic signed [c3vs_pkg::PIX_W-1:0] lstore_prev  [c3vs_pkg::DEF_MAX_WIDTH] = '{default: '0};
    logic signed [c3vs_pkg::PIX_W-1:0] lstore_prev2 [c3vs_pkg::DEF_MAX_WIDTH] = '{default: '0};
    logic signed [c3vs_pkg::PIX_W-1:0] win [3][3] = '{default: '{default: '0}};
    int unsigned            col_cnt = 0;
    int unsigned            row_cnt = 0;

    conv_res_t          conv_q [$];
    dir_step_t          dir_steps [$];
    c3vs_pkg::reg_idx_t kern_regs [3] = '{c3vs_pkg::REG_K_TOP, c3vs_pkg::REG_K_MID,
                                          c3vs_pkg::REG_K_BOT};

    int fail_cnt     = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int shape_count  = 0;
    int cycle_cnt    = 0;
    bit idle_on      = 1'b0;
    bit long_hold_pending = 1'b0;

    function automatic void note_fail(string msg);
        fail_cnt++;
        $error("%s", msg);
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the local model by one pixel; returns 1 when the pixel yields a result
    function automatic bit conv_step(input logic [c3vs_pkg::PIX_W-1:0] px,
                                     output conv_res_t res);
        int unsigned w, h, c, r;
        logic signed [c3vs_pkg::PIX_W-1:0] top, mid;
        longint acc;
        w = clamp_dim(cfg_w, c3vs_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(cfg_h, c3vs_pkg::DEF_MAX_HEIGHT);
        c = col_cnt;
        r = row_cnt;
        // a width shrink can leave the column past the new row end
        if (c >= w) c = w - 1;
        top = lstore_prev2[c];
        mid = lstore_prev[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        lstore_prev2[c] = mid;
        lstore_prev[c]  = px;
        res = '0;
        conv_step = 1'b0;
        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc += longint'(win[i][j]) * longint'($signed(kern[i][16*j +: 16]));
                end
            end
            res.value = acc[c3vs_pkg::SUM_W-1:0];
            res.row   = c3vs_pkg::ROW_W'(r - 2);
            res.col   = c3vs_pkg::COL_W'(c - 2);
            res.last  = (r + 1 >= h) && (c + 1 >= w);
            conv_step = 1'b1;
        end
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // pixels still needed to reach the end of the current frame
    function automatic int frame_left();
        int unsigned w, h, c;
        w = clamp_dim(cfg_w, c3vs_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(cfg_h, c3vs_pkg::DEF_MAX_HEIGHT);
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        return int'(w - c) + ((row_cnt + 1 >= h) ? 0 : int'((h - 1 - row_cnt) * w));
    endfunction

    function automatic logic [c3vs_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [c3vs_pkg::APB_DW-1:0] rand_kernel();
        case ($urandom_range(0, 5))
            0: return {16'($urandom), {3{16'h8000}}};
            1: return {16'h0000, {3{16'h7FFF}}};
            2: return {16'h0000, 16'($urandom_range(0, 8) - 4),
                       16'($urandom_range(0, 8) - 4), 16'($urandom_range(0, 8) - 4)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic dir_step_t reg_row(c3vs_pkg::reg_idx_t idx,
                                          logic [c3vs_pkg::APB_DW-1:0] v);
        return '{STEP_WRITE, idx, v, '0, 1'b0, '0};
    endfunction

    function automatic dir_step_t pixel_row(logic [c3vs_pkg::PIX_W-1:0] px);
        return '{STEP_PIXEL, c3vs_pkg::REG_IMG_W, '0, px, 1'b0, '0};
    endfunction

    function automatic dir_step_t checked_row(logic [c3vs_pkg::PIX_W-1:0] px,
                                              logic signed [c3vs_pkg::SUM_W-1:0] v,
                                              logic [c3vs_pkg::ROW_W-1:0] r,
                                              logic [c3vs_pkg::COL_W-1:0] c,
                                              logic l);
        return '{STEP_PIXEL, c3vs_pkg::REG_IMG_W, '0, px, 1'b1, '{v, r, c, l}};
    endfunction

    // APB write followed by a read-back of the same register
    task automatic cfg_write(c3vs_pkg::reg_idx_t idx, logic [c3vs_pkg::APB_DW-1:0] val);
        logic [c3vs_pkg::APB_DW-1:0] want;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            c3vs_pkg::REG_IMG_W: begin
                cfg_w = val[c3vs_pkg::IMG_W_W-1:0];
                want  = c3vs_pkg::APB_DW'(cfg_w);
            end
            c3vs_pkg::REG_IMG_H: begin
                cfg_h = val[c3vs_pkg::IMG_H_W-1:0];
                want  = c3vs_pkg::APB_DW'(cfg_h);
            end
            c3vs_pkg::REG_K_TOP: begin
                kern[0] = val[c3vs_pkg::KROW_W-1:0];
                want    = c3vs_pkg::APB_DW'(kern[0]);
            end
            c3vs_pkg::REG_K_MID: begin
                kern[1] = val[c3vs_pkg::KROW_W-1:0];
                want    = c3vs_pkg::APB_DW'(kern[1]);
            end
            default: begin
                kern[2] = val[c3vs_pkg::KROW_W-1:0];
                want    = c3vs_pkg::APB_DW'(kern[2]);
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            note_fail($sformatf("prdata %s exp %h act %h", idx.name(), want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(logic [c3vs_pkg::PIX_W-1:0] px, bit typed,
                              conv_res_t typed_res);
        conv_res_t res;
        bit made;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        made = conv_step(px, res);
        if (made) conv_q.push_back(typed ? typed_res : res);
        pixels_sent++;
    endtask

    // stop sending, let every expected result out, then let no-result items clear the pipe
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (conv_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic run_phase(logic [c3vs_pkg::APB_DW-1:0] w_val,
                             logic [c3vs_pkg::APB_DW-1:0] h_val,
                             int frames, int loose, bit reload_kernel, int hold_at);
        int n;
        drain_block();
        // growing the row mid-frame would read line-store entries never written
        if ((col_cnt == 0 && row_cnt == 0) ||
            clamp_dim(w_val[c3vs_pkg::IMG_W_W-1:0], c3vs_pkg::DEF_MAX_WIDTH) <=
            clamp_dim(cfg_w, c3vs_pkg::DEF_MAX_WIDTH)) begin
            cfg_write(c3vs_pkg::REG_IMG_W, w_val);
        end
        cfg_write(c3vs_pkg::REG_IMG_H, h_val);
        if (reload_kernel) begin
            foreach (kern_regs[k]) begin
                if ($urandom_range(0, 1) == 0) cfg_write(kern_regs[k], rand_kernel());
            end
        end
        n = (loose > 0) ? loose : frame_left() + (frames - 1) *
            int'(clamp_dim(cfg_w, c3vs_pkg::DEF_MAX_WIDTH) *
                 clamp_dim(cfg_h, c3vs_pkg::DEF_MAX_HEIGHT));
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) long_hold_pending = 1'b1;
            send_pixel(rand_pixel(), 1'b0, '0);
        end
        shape_count++;
    endtask

    // output side: random back-pressure bursts plus one long hold on request
    always @(posedge aclk) begin : out_ready
        int stall_left;
        if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left = LONG_HOLD;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        conv_res_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[c3vs_pkg::SUM_W-1:0];
            got.row   = m_tdata[c3vs_pkg::SUM_W +: c3vs_pkg::ROW_W];
            got.col   = m_tdata[c3vs_pkg::SUM_W+c3vs_pkg::ROW_W +: c3vs_pkg::COL_W];
            got.last  = m_tlast;
            if (conv_q.size() == 0) begin
                note_fail($sformatf("result with none expected: value %0d row %0d col %0d",
                                    got.value, got.row, got.col));
            end else begin
                want = conv_q.pop_front();
                results_seen++;
                if (got.value !== want.value)
                    note_fail($sformatf("conv_value exp %0d act %0d", want.value, got.value));
                if (got.row !== want.row)
                    note_fail($sformatf("out_row exp %0d act %0d", want.row, got.row));
                if (got.col !== want.col)
                    note_fail($sformatf("out_col exp %0d act %0d", want.col, got.col));
                if (got.last !== want.last)
                    note_fail($sformatf("last_of_frame exp %0d act %0d", want.last, got.last));
            end
        end
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, conv_q.size());
        $display("** conv3x3_valid_stream_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int base;
        logic [c3vs_pkg::APB_DW-1:0] wv, hv;

        // 3x3 frames of extreme pixels against an all-minimum kernel, sizes below range
        dir_steps.push_back(reg_row(c3vs_pkg::REG_K_TOP, 64'hFFFF_8000_8000_8000));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_K_MID, 64'h0000_8000_8000_8000));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_K_BOT, 64'h0000_8000_8000_8000));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_IMG_W, 64'd1));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_IMG_H, 64'd0));
        repeat (8) dir_steps.push_back(pixel_row(16'h8000));
        dir_steps.push_back(checked_row(16'h8000, 35'sd9663676416, 0, 0, 1'b1));
        repeat (8) dir_steps.push_back(pixel_row(16'h7FFF));
        dir_steps.push_back(checked_row(16'h7FFF, -35'sd9663381504, 0, 0, 1'b1));
        // taller frame cut short by a height shrink in the middle of row two
        dir_steps.push_back(reg_row(c3vs_pkg::REG_K_MID, 64'h0000_7FFF_0001_FFFF));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_IMG_H, 64'd5));
        dir_steps.push_back(pixel_row(16'h0000));
        dir_steps.push_back(pixel_row(16'hFFFF));
        dir_steps.push_back(pixel_row(16'h0001));
        dir_steps.push_back(pixel_row(16'h5555));
        dir_steps.push_back(pixel_row(16'hAAAA));
        dir_steps.push_back(pixel_row(16'h7FFE));
        dir_steps.push_back(pixel_row(16'h8001));
        dir_steps.push_back(reg_row(c3vs_pkg::REG_IMG_H, 64'd1));
        dir_steps.push_back(pixel_row(16'h1234));
        dir_steps.push_back(pixel_row(16'hFEDC));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        foreach (dir_steps[k]) begin
            if (dir_steps[k].kind == STEP_WRITE) begin
                drain_block();
                cfg_write(dir_steps[k].regi, dir_steps[k].wval);
            end else begin
                send_pixel(dir_steps[k].pix, dir_steps[k].typed, dir_steps[k].res);
            end
        end

        // widest rows; output held off once results flow so the input backs up
        idle_on = 1'b0;
        run_phase(64'd63, 64'd5, 1, 0, 1'b1, 70);
        // narrowest rows with the height register above range
        idle_on = 1'b1;
        run_phase(64'd2, 64'd2047, 0, NARROW_RUN, 1'b1, -1);

        base = pixels_sent;
        while (pixels_sent - base < RAND_ITEMS) begin
            idle_on = (pixels_sent - base < RAND_ITEMS - 300) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1:    wv = 64'($urandom_range(0, 2));
                2:       wv = 64'($urandom_range(32, 63));
                3:       wv = 64'($urandom_range(9, 31));
                default: wv = 64'($urandom_range(3, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       hv = 64'($urandom_range(0, 2));
                1:       hv = 64'($urandom_range(7, 12));
                default: hv = 64'($urandom_range(3, 6));
            endcase
            // unused upper bits of the size registers
            if ($urandom_range(0, 3) == 0) wv[63:c3vs_pkg::IMG_W_W] = 58'({$urandom, $urandom});
            if ($urandom_range(0, 3) == 0) hv[63:c3vs_pkg::IMG_H_W] = 53'({$urandom, $urandom});
            if ($urandom_range(0, 4) == 0) begin
                run_phase(wv, hv, 0, $urandom_range(1, 40), 1'b1, -1);
            end else begin
                run_phase(wv, hv, $urandom_range(1, 3), 0, 1'b1, -1);
            end
        end

        drain_block();
        $display("conv3x3 run: %0d pixels in, %0d results checked, %0d frame shapes",
                 pixels_sent, results_seen, shape_count);
        $display("sizes clamped both ways, 32-wide rows, a long run of 3-wide rows, long output hold");
        if (fail_cnt == 0) begin
            $display("** conv3x3_valid_stream_top: PASSED **");
        end else begin
            $display("** conv3x3_valid_stream_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/c3vs_pkg.sv
rtl/core/c3vs_scan_ctrl.sv
rtl/core/c3vs_line_buf.sv
rtl/core/c3vs_col_cell.sv
rtl/core/conv3x3_valid_stream_top.sv
test/conv3x3_valid_stream_top_test.sv
